@@ design/paik_pkg.sv @@
// shared constants, types and the arctangent table for the arm solver
// no dependencies; imported by paik_vec_angle and planar_arm_inverse_kinematics
package paik_pkg;

   localparam int POS_W   = 16;                 // coordinate width, signed q8.8
   localparam int LEN_W   = 15;                 // link length width, unsigned q7.8
   localparam int HGT_W   = 16;                 // base height width, signed q8.8
   localparam int ANG_W   = 16;                 // angle output width, signed q4.12
   localparam int SLIDE_W = 16;                 // slide output width, signed q8.8
   localparam int STAT_W  = 2;
   localparam int CSR_W   = (HGT_W > LEN_W) ? HGT_W : LEN_W;
   localparam int CSR_IDX_W = 2;

   localparam int SQ_W    = 2 * POS_W + 1;      // x^2 + y^2
   localparam int LSQ_W   = 2 * (LEN_W + 1);    // (l1 + l2)^2
   localparam int CMP_W   = ((SQ_W > LSQ_W) ? SQ_W : LSQ_W) + 2;
   localparam int DEN_W   = 2 * LEN_W + 1;      // 2*l1*l2
   localparam int FAC_W   = DEN_W + 1;          // den - num, den + num
   localparam int RAD_W   = 2 * FAC_W - 2;      // radicand, below 2^62
   localparam int ROOT_W  = RAD_W / 2;
   localparam int REM_W   = ROOT_W + 3;
   localparam int VEC_W   = FAC_W + 2;          // atan2 operand width
   localparam int SHIFT_W = $clog2(VEC_W);
   localparam int NORM_BIT = 30;                // normalized magnitude msb
   localparam int ITERS   = 16;
   localparam int Z_W     = 20;                 // q16 angle accumulator
   localparam int TH_W    = Z_W + 2;
   localparam int ROUND_SHIFT = 4;              // q16 to q4.12
   localparam int CORDIC_LAT  = ITERS + 4;

   localparam int D3_W = ((HGT_W > POS_W) ? HGT_W : POS_W) + 1;
   localparam logic signed [D3_W-1:0] SLIDE_MAX = D3_W'((2 ** (SLIDE_W - 1)) - 1);
   localparam logic signed [D3_W-1:0] SLIDE_MIN = D3_W'(-(2 ** (SLIDE_W - 1)));

   localparam logic signed [Z_W-1:0] PI_Q16 = Z_W'(205887);

   localparam logic [LEN_W-1:0] UPPER_RESET = LEN_W'(512);
   localparam logic [LEN_W-1:0] LOWER_RESET = LEN_W'(256);
   localparam logic signed [HGT_W-1:0] BASE_RESET = HGT_W'(896);

   typedef enum logic [STAT_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_REACH = 2'd1,
      STAT_AXIS  = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_UPPER = 2'd0,
      CSR_LOWER = 2'd1,
      CSR_BASE  = 2'd2
   } csr_index_type;

   function automatic logic signed [Z_W-1:0] atan_q16(input logic [3:0] i);
      logic signed [Z_W-1:0] a;
      unique case (i)
         4'd0:  a = Z_W'(51472);
         4'd1:  a = Z_W'(30386);
         4'd2:  a = Z_W'(16055);
         4'd3:  a = Z_W'(8150);
         4'd4:  a = Z_W'(4091);
         4'd5:  a = Z_W'(2047);
         4'd6:  a = Z_W'(1024);
         4'd7:  a = Z_W'(512);
         4'd8:  a = Z_W'(256);
         4'd9:  a = Z_W'(128);
         4'd10: a = Z_W'(64);
         4'd11: a = Z_W'(32);
         4'd12: a = Z_W'(16);
         4'd13: a = Z_W'(8);
         4'd14: a = Z_W'(4);
         4'd15: a = Z_W'(2);
      endcase
      return a;
   endfunction

endpackage

@@ design/paik_vec_angle.sv @@
// pipelined vectoring cordic: atan2(y, x) in q16 radians, one item per cycle
// depends on paik_pkg
module paik_vec_angle (
   input  logic                              clock,
   input  logic signed [paik_pkg::VEC_W-1:0] in_y,
   input  logic signed [paik_pkg::VEC_W-1:0] in_x,
   output logic signed [paik_pkg::Z_W-1:0]   out_angle
);
   import paik_pkg::*;

   // quadrant fold
   logic signed [VEC_W:0]   xm_in, ym_in;
   logic signed [Z_W-1:0]   off0_in, off0_ff;
   logic [VEC_W-1:0]        ax0_in, ay0_in, ax0_ff, ay0_ff;
   logic                    neg0_in, neg0_ff;

   // leading one search
   logic [VEC_W-1:0]        m1;
   logic [SHIFT_W-1:0]      p1_in, p1_ff;
   logic [VEC_W-1:0]        ax1_ff, ay1_ff;
   logic                    neg1_ff, zero1_ff;
   logic signed [Z_W-1:0]   off1_ff;

   // normalize and micro-rotations
   logic [VEC_W-1:0]        sx2, sy2;
   logic signed [VEC_W-1:0] xs_in [ITERS+1];
   logic signed [VEC_W-1:0] ys_in [ITERS+1];
   logic signed [Z_W-1:0]   zs_in [ITERS+1];
   logic signed [VEC_W-1:0] xs_ff [ITERS+1];
   logic signed [VEC_W-1:0] ys_ff [ITERS+1];
   logic signed [Z_W-1:0]   zs_ff [ITERS+1];
   logic                    zero_ff [ITERS+1];
   logic signed [Z_W-1:0]   off_ff [ITERS+1];
   logic signed [Z_W-1:0]   angle_in, angle_ff;

   always_comb begin
      if (in_x < 0) begin
         off0_in = (in_y >= 0) ? PI_Q16 : -PI_Q16;
         xm_in   = -{in_x[VEC_W-1], in_x};
         ym_in   = -{in_y[VEC_W-1], in_y};
      end else begin
         off0_in = '0;
         xm_in   = {in_x[VEC_W-1], in_x};
         ym_in   = {in_y[VEC_W-1], in_y};
      end
      neg0_in = ym_in < 0;
      ax0_in  = xm_in[VEC_W-1:0];
      ay0_in  = neg0_in ? (VEC_W'(-ym_in)) : ym_in[VEC_W-1:0];
   end

   always_comb begin
      m1    = (ax0_ff > ay0_ff) ? ax0_ff : ay0_ff;
      p1_in = '0;
      for (int i = 0; i < VEC_W; i++) begin
         if (m1[i]) begin
            p1_in = SHIFT_W'(i);
         end
      end
   end

   always_comb begin
      if (p1_ff > SHIFT_W'(NORM_BIT)) begin
         sx2 = ax1_ff >> (p1_ff - SHIFT_W'(NORM_BIT));
         sy2 = ay1_ff >> (p1_ff - SHIFT_W'(NORM_BIT));
      end else begin
         sx2 = ax1_ff << (SHIFT_W'(NORM_BIT) - p1_ff);
         sy2 = ay1_ff << (SHIFT_W'(NORM_BIT) - p1_ff);
      end
      xs_in[0] = signed'(sx2);
      ys_in[0] = neg1_ff ? -signed'(sy2) : signed'(sy2);
      zs_in[0] = '0;
      for (int k = 0; k < ITERS; k++) begin
         if (ys_ff[k] < 0) begin
            xs_in[k+1] = xs_ff[k] - (ys_ff[k] >>> k);
            ys_in[k+1] = ys_ff[k] + (xs_ff[k] >>> k);
            zs_in[k+1] = zs_ff[k] - atan_q16(4'(k));
         end else begin
            xs_in[k+1] = xs_ff[k] + (ys_ff[k] >>> k);
            ys_in[k+1] = ys_ff[k] - (xs_ff[k] >>> k);
            zs_in[k+1] = zs_ff[k] + atan_q16(4'(k));
         end
      end
      // zero vector gives just the fold offset
      angle_in = zero_ff[ITERS] ? off_ff[ITERS] : off_ff[ITERS] + zs_ff[ITERS];
   end

   always_ff @(posedge clock) begin
      off0_ff  <= off0_in;
      ax0_ff   <= ax0_in;
      ay0_ff   <= ay0_in;
      neg0_ff  <= neg0_in;
      p1_ff    <= p1_in;
      ax1_ff   <= ax0_ff;
      ay1_ff   <= ay0_ff;
      neg1_ff  <= neg0_ff;
      zero1_ff <= (m1 == '0);
      off1_ff  <= off0_ff;
      for (int k = 0; k <= ITERS; k++) begin
         xs_ff[k] <= xs_in[k];
         ys_ff[k] <= ys_in[k];
         zs_ff[k] <= zs_in[k];
      end
      zero_ff[0] <= zero1_ff;
      off_ff[0]  <= off1_ff;
      for (int k = 1; k <= ITERS; k++) begin
         zero_ff[k] <= zero_ff[k-1];
         off_ff[k]  <= off_ff[k-1];
      end
      angle_ff <= angle_in;
   end

   assign out_angle = angle_ff;

endmodule

@@ design/planar_arm_inverse_kinematics.sv @@
// two-link planar arm inverse kinematics with a vertical slide, fully pipelined
// one item accepted every cycle, busy stays low
// the isqrt (31 stages) and the three parallel cordic units (20 stages) set the depth
// reset (synchronous, active high) clears all valid bits and loads the default link lengths
// depends on paik_pkg and paik_vec_angle
module planar_arm_inverse_kinematics (
   input  logic                                  clock,
   input  logic                                  reset,
   // item input
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [paik_pkg::POS_W-1:0]     req_x_pos,
   input  logic signed [paik_pkg::POS_W-1:0]     req_y_pos,
   input  logic signed [paik_pkg::POS_W-1:0]     req_z_pos,
   // result output, one-cycle strobe
   output logic                                  rsp_valid,
   output logic signed [paik_pkg::ANG_W-1:0]     rsp_shoulder_angle,
   output logic signed [paik_pkg::ANG_W-1:0]     rsp_elbow_angle,
   output logic signed [paik_pkg::SLIDE_W-1:0]   rsp_slide_extent,
   output logic [paik_pkg::STAT_W-1:0]           rsp_solve_status,
   // register writes
   input  logic                                  csr_write_enable,
   input  logic [paik_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [paik_pkg::CSR_W-1:0]            csr_write_data
);
   import paik_pkg::*;

   // configuration registers
   logic [LEN_W-1:0]        upper_len_ff, lower_len_ff;
   logic signed [HGT_W-1:0] base_hgt_ff;

   // stage 1: squares and slide
   logic                    vld1_ff;
   logic signed [POS_W-1:0] x1_ff, y1_ff;
   logic [2*POS_W-1:0]      xsq1_ff, ysq1_ff;
   logic [2*LEN_W-1:0]      l1sq1_ff, l2sq1_ff, l1l21_ff;
   logic [LSQ_W-1:0]        lo1_ff, hi1_ff;
   logic                    axis1_ff;
   logic signed [SLIDE_W-1:0] d31_ff;
   logic signed [LEN_W:0]   ldiff;
   logic [LEN_W:0]          lsum;
   logic signed [D3_W-1:0]  d3_raw;
   logic signed [SLIDE_W-1:0] d3_in;

   // stage 2: radius, reach, cosine numerators
   logic                    vld2_ff;
   logic signed [POS_W-1:0] x2_ff, y2_ff;
   logic [SQ_W-1:0]         r2;
   status_type              stat2_in, stat2_ff;
   logic signed [CMP_W-1:0] num2_ff, pc2_ff;
   logic [DEN_W-1:0]        den2_ff;
   logic signed [SLIDE_W-1:0] d32_ff;

   // stage 3: factors of den^2 - num^2
   logic                    vld3_ff;
   logic signed [POS_W-1:0] x3_ff, y3_ff;
   status_type              stat3_ff;
   logic signed [CMP_W-1:0] den_ext, fa3_full, fb3_full;
   logic [FAC_W-1:0]        fa3_ff, fb3_ff;
   logic signed [VEC_W-1:0] num3_ff, pc3_ff;
   logic signed [SLIDE_W-1:0] d33_ff;
   logic [2*FAC_W-1:0]      prod;

   // isqrt pipeline, index 0 holds the radicand
   logic                    sq_vld_ff  [ROOT_W+1];
   logic [RAD_W-1:0]        sq_rad_ff  [ROOT_W+1];
   logic [REM_W-1:0]        sq_rem_ff  [ROOT_W+1];
   logic [ROOT_W-1:0]       sq_root_ff [ROOT_W+1];
   logic [RAD_W-1:0]        sq_rad_in  [ROOT_W+1];
   logic [REM_W-1:0]        sq_rem_in  [ROOT_W+1];
   logic [ROOT_W-1:0]       sq_root_in [ROOT_W+1];
   logic [REM_W-1:0]        rem_t      [ROOT_W];
   logic [REM_W-1:0]        trial      [ROOT_W];
   logic signed [POS_W-1:0] sq_x_ff    [ROOT_W+1];
   logic signed [POS_W-1:0] sq_y_ff    [ROOT_W+1];
   logic signed [VEC_W-1:0] sq_num_ff  [ROOT_W+1];
   logic signed [VEC_W-1:0] sq_pc_ff   [ROOT_W+1];
   status_type              sq_stat_ff [ROOT_W+1];
   logic signed [SLIDE_W-1:0] sq_d3_ff [ROOT_W+1];

   // cordic operands and side delay
   logic signed [VEC_W-1:0] root_vec, x_vec, y_vec;
   logic signed [Z_W-1:0]   el_z, beta_z, dir_z;
   logic                    cd_vld_ff  [CORDIC_LAT];
   status_type              cd_stat_ff [CORDIC_LAT];
   logic signed [SLIDE_W-1:0] cd_d3_ff [CORDIC_LAT];

   // output stage
   logic signed [TH_W-1:0]  th1, th1_rnd, th2_rnd;
   logic                    out_vld_ff;
   logic signed [ANG_W-1:0] out_sh_ff, out_el_ff;
   logic signed [SLIDE_W-1:0] out_d3_ff;
   status_type              out_stat_ff;

   // every cycle takes an item
   assign busy = 1'b0;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         upper_len_ff <= UPPER_RESET;
         lower_len_ff <= LOWER_RESET;
         base_hgt_ff  <= BASE_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_UPPER: upper_len_ff <= csr_write_data[LEN_W-1:0];
            CSR_LOWER: lower_len_ff <= csr_write_data[LEN_W-1:0];
            CSR_BASE:  base_hgt_ff  <= signed'(csr_write_data[HGT_W-1:0]);
            default: ;
         endcase
      end
   end

   // stage 1 logic: one multiplier per product, slide saturation
   always_comb begin
      ldiff  = signed'({1'b0, upper_len_ff}) - signed'({1'b0, lower_len_ff});
      lsum   = {1'b0, upper_len_ff} + {1'b0, lower_len_ff};
      d3_raw = D3_W'(base_hgt_ff) - D3_W'(req_z_pos);
      if (d3_raw > SLIDE_MAX) begin
         d3_in = SLIDE_MAX[SLIDE_W-1:0];
      end else if (d3_raw < SLIDE_MIN) begin
         d3_in = SLIDE_MIN[SLIDE_W-1:0];
      end else begin
         d3_in = d3_raw[SLIDE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      x1_ff    <= req_x_pos;
      y1_ff    <= req_y_pos;
      xsq1_ff  <= unsigned'((2*POS_W)'(req_x_pos * req_x_pos));
      ysq1_ff  <= unsigned'((2*POS_W)'(req_y_pos * req_y_pos));
      l1sq1_ff <= (2*LEN_W)'(upper_len_ff * upper_len_ff);
      l2sq1_ff <= (2*LEN_W)'(lower_len_ff * lower_len_ff);
      l1l21_ff <= (2*LEN_W)'(upper_len_ff * lower_len_ff);
      lo1_ff   <= unsigned'(LSQ_W'(ldiff * ldiff));
      hi1_ff   <= LSQ_W'(lsum * lsum);
      axis1_ff <= (req_x_pos == '0) && (req_y_pos == '0);
      d31_ff   <= d3_in;
   end

   // stage 2 logic: base axis ahead of the reach test
   always_comb begin
      r2 = SQ_W'(xsq1_ff) + SQ_W'(ysq1_ff);
      if (axis1_ff) begin
         stat2_in = STAT_AXIS;
      end else if ((CMP_W'(r2) < CMP_W'(lo1_ff)) || (CMP_W'(r2) > CMP_W'(hi1_ff))) begin
         stat2_in = STAT_REACH;
      end else begin
         stat2_in = STAT_OK;
      end
   end

   always_ff @(posedge clock) begin
      x2_ff    <= x1_ff;
      y2_ff    <= y1_ff;
      stat2_ff <= stat2_in;
      num2_ff  <= signed'(CMP_W'(r2)) - signed'(CMP_W'(l1sq1_ff)) - signed'(CMP_W'(l2sq1_ff));
      pc2_ff   <= signed'(CMP_W'(l1sq1_ff)) + signed'(CMP_W'(r2)) - signed'(CMP_W'(l2sq1_ff));
      den2_ff  <= {l1l21_ff, 1'b0};
      d32_ff   <= d31_ff;
   end

   // stage 3: den -/+ num; in reach both are below 2^32
   always_comb begin
      den_ext  = signed'(CMP_W'(den2_ff));
      fa3_full = den_ext - num2_ff;
      fb3_full = den_ext + num2_ff;
   end

   always_ff @(posedge clock) begin
      x3_ff    <= x2_ff;
      y3_ff    <= y2_ff;
      stat3_ff <= stat2_ff;
      fa3_ff   <= fa3_full[FAC_W-1:0];
      fb3_ff   <= fb3_full[FAC_W-1:0];
      num3_ff  <= num2_ff[VEC_W-1:0];
      pc3_ff   <= pc2_ff[VEC_W-1:0];
      d33_ff   <= d32_ff;
   end

   // stage 4 is the radicand product
   assign prod = fa3_ff * fb3_ff;

   // restoring square root, one result bit per stage
   always_comb begin
      sq_rad_in[0]  = prod[RAD_W-1:0];
      sq_rem_in[0]  = '0;
      sq_root_in[0] = '0;
      for (int k = 0; k < ROOT_W; k++) begin
         rem_t[k] = {sq_rem_ff[k][REM_W-3:0], sq_rad_ff[k][RAD_W-1 -: 2]};
         trial[k] = {1'b0, sq_root_ff[k], 2'b01};
         sq_rad_in[k+1] = sq_rad_ff[k] << 2;
         if (rem_t[k] >= trial[k]) begin
            sq_rem_in[k+1]  = rem_t[k] - trial[k];
            sq_root_in[k+1] = {sq_root_ff[k][ROOT_W-2:0], 1'b1};
         end else begin
            sq_rem_in[k+1]  = rem_t[k];
            sq_root_in[k+1] = {sq_root_ff[k][ROOT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= ROOT_W; k++) begin
         sq_rad_ff[k]  <= sq_rad_in[k];
         sq_rem_ff[k]  <= sq_rem_in[k];
         sq_root_ff[k] <= sq_root_in[k];
      end
      sq_x_ff[0]    <= x3_ff;
      sq_y_ff[0]    <= y3_ff;
      sq_num_ff[0]  <= num3_ff;
      sq_pc_ff[0]   <= pc3_ff;
      sq_stat_ff[0] <= stat3_ff;
      sq_d3_ff[0]   <= d33_ff;
      for (int k = 1; k <= ROOT_W; k++) begin
         sq_x_ff[k]    <= sq_x_ff[k-1];
         sq_y_ff[k]    <= sq_y_ff[k-1];
         sq_num_ff[k]  <= sq_num_ff[k-1];
         sq_pc_ff[k]   <= sq_pc_ff[k-1];
         sq_stat_ff[k] <= sq_stat_ff[k-1];
         sq_d3_ff[k]   <= sq_d3_ff[k-1];
      end
   end

   // valid bits for every stage up to the output
   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         for (int k = 0; k <= ROOT_W; k++) begin
            sq_vld_ff[k] <= 1'b0;
         end
         for (int k = 0; k < CORDIC_LAT; k++) begin
            cd_vld_ff[k] <= 1'b0;
         end
         out_vld_ff <= 1'b0;
      end else begin
         vld1_ff      <= start & ~busy;
         vld2_ff      <= vld1_ff;
         vld3_ff      <= vld2_ff;
         sq_vld_ff[0] <= vld3_ff;
         for (int k = 1; k <= ROOT_W; k++) begin
            sq_vld_ff[k] <= sq_vld_ff[k-1];
         end
         cd_vld_ff[0] <= sq_vld_ff[ROOT_W];
         for (int k = 1; k < CORDIC_LAT; k++) begin
            cd_vld_ff[k] <= cd_vld_ff[k-1];
         end
         out_vld_ff <= cd_vld_ff[CORDIC_LAT-1];
      end
   end

   // three atan2 units run side by side
   assign root_vec = signed'({{(VEC_W-ROOT_W){1'b0}}, sq_root_ff[ROOT_W]});
   assign x_vec    = {{(VEC_W-POS_W){sq_x_ff[ROOT_W][POS_W-1]}}, sq_x_ff[ROOT_W]};
   assign y_vec    = {{(VEC_W-POS_W){sq_y_ff[ROOT_W][POS_W-1]}}, sq_y_ff[ROOT_W]};

   paik_vec_angle u_elbow (
      .clock     (clock),
      .in_y      (root_vec),
      .in_x      (sq_num_ff[ROOT_W]),
      .out_angle (el_z)
   );

   paik_vec_angle u_beta (
      .clock     (clock),
      .in_y      (root_vec),
      .in_x      (sq_pc_ff[ROOT_W]),
      .out_angle (beta_z)
   );

   paik_vec_angle u_dir (
      .clock     (clock),
      .in_y      (y_vec),
      .in_x      (x_vec),
      .out_angle (dir_z)
   );

   // status and slide ride along the cordic depth
   always_ff @(posedge clock) begin
      cd_stat_ff[0] <= sq_stat_ff[ROOT_W];
      cd_d3_ff[0]   <= sq_d3_ff[ROOT_W];
      for (int k = 1; k < CORDIC_LAT; k++) begin
         cd_stat_ff[k] <= cd_stat_ff[k-1];
         cd_d3_ff[k]   <= cd_d3_ff[k-1];
      end
   end

   // shoulder = direction - beta; shoulder and elbow then round half up to q4.12
   always_comb begin
      th1     = {{2{dir_z[Z_W-1]}}, dir_z} - {{2{beta_z[Z_W-1]}}, beta_z};
      th1_rnd = (th1 + TH_W'(8)) >>> ROUND_SHIFT;
      th2_rnd = ({{2{el_z[Z_W-1]}}, el_z} + TH_W'(8)) >>> ROUND_SHIFT;
   end

   always_ff @(posedge clock) begin
      out_stat_ff <= cd_stat_ff[CORDIC_LAT-1];
      out_d3_ff   <= cd_d3_ff[CORDIC_LAT-1];
      // angles only mean something for a reachable target
      if (cd_stat_ff[CORDIC_LAT-1] == STAT_OK) begin
         out_sh_ff <= th1_rnd[ANG_W-1:0];
         out_el_ff <= th2_rnd[ANG_W-1:0];
      end else begin
         out_sh_ff <= '0;
         out_el_ff <= '0;
      end
   end

   assign rsp_valid          = out_vld_ff;
   assign rsp_shoulder_angle = out_sh_ff;
   assign rsp_elbow_angle    = out_el_ff;
   assign rsp_slide_extent   = out_d3_ff;
   assign rsp_solve_status   = out_stat_ff;

   // failed solve must not leak cordic angles
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_solve_status != STAT_OK)) |->
         ((rsp_shoulder_angle == '0) && (rsp_elbow_angle == '0)))
      else $error("angles nonzero on failed solve");

   // square root remainder bound for a reachable target
   assert property (@(posedge clock) disable iff (reset)
      (sq_vld_ff[ROOT_W] && (sq_stat_ff[ROOT_W] == STAT_OK)) |->
         (sq_rem_ff[ROOT_W] <= {2'b00, sq_root_ff[ROOT_W], 1'b0}))
      else $error("isqrt remainder too large");

   // upper link write lands in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (csr_write_enable && (csr_index == CSR_UPPER)) |=>
         (upper_len_ff == $past(csr_write_data[LEN_W-1:0])))
      else $error("upper link length write lost");

endmodule

@@ test/tb_planar_arm_inverse_kinematics.sv @@
// self-checking testbench for planar_arm_inverse_kinematics: an in-bench integer predictor
// with cordic and isqrt checks every result; depends on paik_pkg and the design files
module tb_planar_arm_inverse_kinematics;
   timeunit 1ns;
   timeprecision 1ps;
   import paik_pkg::*;

   typedef struct {
      logic signed [ANG_W-1:0]   shoulder;
      logic signed [ANG_W-1:0]   elbow;
      logic signed [SLIDE_W-1:0] slide;
      status_type                status;
   } joint_solution_type;

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        start;
   logic                        busy;
   logic signed [POS_W-1:0]     req_x_pos, req_y_pos, req_z_pos;
   logic                        rsp_valid;
   logic signed [ANG_W-1:0]     rsp_shoulder_angle, rsp_elbow_angle;
   logic signed [SLIDE_W-1:0]   rsp_slide_extent;
   logic [STAT_W-1:0]           rsp_solve_status;
   logic                        csr_write_enable;
   logic [CSR_IDX_W-1:0]        csr_index;
   logic [CSR_W-1:0]            csr_write_data;

   // local copy of the arm geometry
   longint             upper_len, lower_len, base_hgt;
   joint_solution_type pending_solutions[$];
   int                 error_count = 0;
   int                 item_count = 0;
   int                 cycle_count = 0;
   bit                 gaps_enabled = 1'b1;

   localparam int  CYCLE_LIMIT = 300000;
   localparam int  DRAIN_CYCLES = 64;       // a margin beyond the pipeline depth

   planar_arm_inverse_kinematics uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------- predictor
   // arctangent table in q16 radians
   localparam longint ATAN_Q16[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                       256, 128, 64, 32, 16, 8, 4, 2};
   localparam longint HALF_TURN = 205887;   // pi in q16

   function automatic longint unsigned floor_root(longint unsigned v);
      longint unsigned res, bit_w;
      res = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > v) bit_w >>= 2;
      while (bit_w != 0) begin
         if (v >= res + bit_w) begin
            v -= res + bit_w;
            res = (res >> 1) + bit_w;
         end else begin
            res >>= 1;
         end
         bit_w >>= 2;
      end
      return res;
   endfunction

   // vectoring cordic, atan2(yv, xv) in q16
   function automatic longint cordic_angle(longint yv, longint xv);
      longint offset, ax, ay, mag, cx, cy, acc, dx, dy;
      bit     neg;
      offset = 0;
      acc = 0;
      if (xv < 0) begin
         // fold into the right half plane
         offset = (yv >= 0) ? HALF_TURN : -HALF_TURN;
         xv = -xv;
         yv = -yv;
      end
      neg = yv < 0;
      ax = xv;
      ay = neg ? -yv : yv;
      mag = (ax > ay) ? ax : ay;
      if (mag == 0) return offset;
      while (mag >= (64'sd1 << 31)) begin
         ax >>= 1; ay >>= 1; mag >>= 1;
      end
      while (mag < (64'sd1 << 30)) begin
         ax <<= 1; ay <<= 1; mag <<= 1;
      end
      cx = ax;
      cy = neg ? -ay : ay;
      for (int i = 0; i < 16; i++) begin
         dx = cy >>> i;
         dy = cx >>> i;
         if (cy < 0) begin
            cx -= dx; cy += dy; acc -= ATAN_Q16[i];
         end else begin
            cx += dx; cy -= dy; acc += ATAN_Q16[i];
         end
      end
      return offset + acc;
   endfunction

   function automatic logic signed [ANG_W-1:0] to_q4_12(longint a);
      longint r;
      r = (a + 8) >>> 4;
      return r[ANG_W-1:0];
   endfunction

   function automatic joint_solution_type solve_joints(longint x, longint y, longint z);
      joint_solution_type sol;
      longint r2, lo, hi, d3, den, num, pc, s2, th2, beta, th1;
      d3 = base_hgt - z;
      if (d3 > 32767) d3 = 32767;
      if (d3 < -32768) d3 = -32768;
      sol.slide = d3[SLIDE_W-1:0];
      sol.shoulder = '0;
      sol.elbow = '0;
      r2 = x * x + y * y;
      lo = (upper_len - lower_len) * (upper_len - lower_len);
      hi = (upper_len + lower_len) * (upper_len + lower_len);
      if (x == 0 && y == 0) begin
         sol.status = STAT_AXIS;
      end else if (r2 < lo || r2 > hi) begin
         sol.status = STAT_REACH;
      end else begin
         den = 2 * upper_len * lower_len;
         num = r2 - upper_len * upper_len - lower_len * lower_len;
         pc = upper_len * upper_len + r2 - lower_len * lower_len;
         s2 = longint'(floor_root(longint'(unsigned'(den - num) * unsigned'(den + num))));
         th2 = cordic_angle(s2, num);
         beta = cordic_angle(s2, pc);
         th1 = cordic_angle(y, x) - beta;
         sol.status = STAT_OK;
         sol.shoulder = to_q4_12(th1);
         sol.elbow = to_q4_12(th2);
      end
      return sol;
   endfunction

   // ---------------------------------------------------------------- checking
   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want, cycle_count);
      error_count++;
   endtask

   always @(posedge clock) begin
      joint_solution_type want;
      if (!reset && rsp_valid) begin
         if (pending_solutions.size() == 0) begin
            report_mismatch("unexpected result", 1, 0);
         end else begin
            want = pending_solutions.pop_front();
            if (rsp_solve_status !== want.status)
               report_mismatch("solve_status", rsp_solve_status, want.status);
            if (rsp_shoulder_angle !== want.shoulder)
               report_mismatch("shoulder_angle", rsp_shoulder_angle, want.shoulder);
            if (rsp_elbow_angle !== want.elbow)
               report_mismatch("elbow_angle", rsp_elbow_angle, want.elbow);
            if (rsp_slide_extent !== want.slide)
               report_mismatch("slide_extent", rsp_slide_extent, want.slide);
         end
      end
   end

   // ---------------------------------------------------------------- drivers
   // called right after a rising edge; returns at the edge that accepted the item
   task automatic send_target(longint x, longint y, longint z);
      if (gaps_enabled && $urandom_range(99) < 25) begin
         start <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      start <= 1'b1;
      req_x_pos <= x[POS_W-1:0];
      req_y_pos <= y[POS_W-1:0];
      req_z_pos <= z[POS_W-1:0];
      do @(posedge clock); while (busy);
      pending_solutions.push_back(solve_joints(longint'(req_x_pos), longint'(req_y_pos),
                                               longint'(req_z_pos)));
      item_count++;
   endtask

   // lower start and let the pipeline empty
   task automatic drain_results();
      start <= 1'b0;
      while (pending_solutions.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, longint value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value[CSR_W-1:0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_UPPER: upper_len = value & 16'h7FFF;
         CSR_LOWER: lower_len = value & 16'h7FFF;
         default:   base_hgt = longint'(signed'(value[15:0]));
      endcase
   endtask

   task automatic set_geometry(longint l1, longint l2, longint d1);
      write_csr(CSR_UPPER, l1);
      write_csr(CSR_LOWER, l2);
      write_csr(CSR_BASE, d1);
   endtask

   function automatic longint coord_near(longint span);
      longint v;
      if (span > 32767) span = 32767;
      v = longint'($urandom_range(2 * span)) - span;
      return v;
   endfunction

   function automatic longint any_coord();
      return longint'(signed'(16'($urandom)));
   endfunction

   // mostly targets around the workspace, some anywhere
   task automatic send_random_targets(int count);
      longint reach;
      for (int i = 0; i < count; i++) begin
         reach = upper_len + lower_len;
         if ($urandom_range(99) < 72)
            send_target(coord_near(reach), coord_near(reach), any_coord());
         else
            send_target(any_coord(), any_coord(), any_coord());
      end
   endtask

   // ---------------------------------------------------------------- tests
   task automatic test_special_targets();
      // base axis, outside and inside the annulus, exact annulus edges
      send_target(0, 0, 0);
      send_target(0, 0, -32768);
      send_target(768, 0, 0);          // outer edge, zero root
      send_target(256, 0, 0);          // inner edge
      send_target(0, -768, 100);
      send_target(-256, 0, 100);
      send_target(769, 0, 0);          // just past outer edge
      send_target(255, 0, 0);          // just inside inner hole
      send_target(32767, 32767, 32767);
      send_target(-32768, -32768, -32768);
      send_target(-600, 1, 0);         // near the negative x axis
      send_target(-600, -1, 0);
      send_target(400, 400, 0);
      send_target(-400, -400, 0);
      drain_results();
   endtask

   task automatic test_slide_saturation();
      set_geometry(512, 256, 32767);
      send_target(500, 100, -32768);   // saturates high
      send_target(500, 100, 32767);
      drain_results();
      set_geometry(512, 256, -32768);
      send_target(500, 100, 32767);    // saturates low
      send_target(0, 0, -32768);
      drain_results();
   endtask

   task automatic test_extreme_links();
      set_geometry(1, 1, 0);
      send_target(2, 0, 0);
      send_target(1, 1, 0);
      send_target(-1, 0, 0);
      send_random_targets(200);
      drain_results();
      set_geometry(32767, 32767, 12345);
      send_target(32767, 32767, 0);
      send_target(-32768, 1, 0);
      send_random_targets(250);
      drain_results();
      set_geometry(32767, 1, -500);
      send_random_targets(200);
      drain_results();
   endtask

   task automatic test_random_geometries();
      for (int k = 0; k < 6; k++) begin
         set_geometry($urandom_range(32767, 1), $urandom_range(4000, 1),
                      any_coord());
         send_random_targets(100);
         drain_results();
      end
   endtask

   // back to back items with no gaps at all
   task automatic test_full_rate();
      set_geometry(512, 256, 896);
      gaps_enabled = 1'b0;
      send_random_targets(300);
      gaps_enabled = 1'b1;
      drain_results();
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_x_pos = '0;
      req_y_pos = '0;
      req_z_pos = '0;
      csr_write_enable = 1'b0;
      csr_index = CSR_UPPER;
      csr_write_data = '0;
      upper_len = 512;
      lower_len = 256;
      base_hgt = 896;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_special_targets();
      send_random_targets(150);       // reset geometry
      drain_results();
      test_slide_saturation();
      test_extreme_links();
      test_random_geometries();
      test_full_rate();
      $display("covered %0d targets over reset, extreme and random arm geometries,", item_count);
      $display("including base axis, reach limits, slide saturation and full-rate streams");
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches", error_count);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
